// File: rtl/qoi_dec_pkg.sv
package qoi_dec_pkg;

    // One RGBA pixel, red in the top byte of the packed struct.
    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    // Multi-byte chunk that is still gathering its payload.
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_RGB  = 2'd1;
    localparam logic [1:0] OP_RGBA = 2'd2;
    localparam logic [1:0] OP_LUMA = 2'd3;

    // Full-byte tags.
    localparam logic [7:0] TAG_RGB  = 8'hFE;
    localparam logic [7:0] TAG_RGBA = 8'hFF;

    // Two-bit tags in the top bits of a chunk byte.
    localparam logic [1:0] TAG2_INDEX = 2'b00;
    localparam logic [1:0] TAG2_DIFF  = 2'b01;
    localparam logic [1:0] TAG2_LUMA  = 2'b10;
    localparam logic [1:0] TAG2_RUN   = 2'b11;

    // Payload byte counts of the multi-byte chunks.
    localparam logic [2:0] NEED_RGB  = 3'd3;
    localparam logic [2:0] NEED_RGBA = 3'd4;
    localparam logic [2:0] NEED_LUMA = 3'd1;

    // Start pixel and the value of an index entry never written.
    localparam pixel_t PIXEL_RESET = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

    // Register map.
    localparam logic       REG_PIXEL_COUNT   = 1'b0;
    localparam logic [28:0] PIX_COUNT_RESET  = 29'd1;

    // Color hash 3r + 5g + 7b + 11a, modulo 256; callers keep the low bits.
    function automatic logic [7:0] pix_hash(input pixel_t p);
        logic [7:0] sum;
        sum = p.r * 8'd3 + p.g * 8'd5 + p.b * 8'd7 + p.a * 8'd11;
        return sum;
    endfunction

endpackage

// File: rtl/qoi_image_decoder_core.sv
// Channel   Dir  Handshake                 Payload
// s_        in   s_tvalid / s_tready       data_byte in s_tdata, end_of_data in s_tlast
// m_        out  m_tvalid / m_tready       red, green, blue, alpha in m_tdata,
//                                          run_last in m_tlast, image_last in m_tuser
// APB       in   psel, penable, pready     pixel_count at byte address 0
//
// One chunk byte is taken per cycle unless the decoder stalls. A byte that yields pixels
// (a run gives up to 62) waits in the byte stage until the pixel emitter, which sends one
// pixel per cycle while the output register is free, is done with the byte before it.
// The color index lives in a 64-entry memory with registered read; two forwarding
// registers cover writes still in flight. Reset is synchronous; a byte with end_of_data
// clears the index valid bits and the decoder state at once, without a clearing pass.
// Either side may stall at any time; the emitter and the output register buffer results.
module qoi_image_decoder_core
    import qoi_dec_pkg::*;
#(
    parameter int INDEX_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic        m_tlast,
    output logic        m_tuser,   // [0] image_last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_AW = $clog2(INDEX_DEPTH);

    // Configuration.
    logic [28:0] pix_count_reg;

    // Byte stage.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_first_reg;
    pixel_t      s1_held_reg;
    logic        s_accept;
    logic        s1_fire;

    // Color index memory, its valid bits and write forwarding.
    pixel_t                idx_mem [INDEX_DEPTH];
    pixel_t                rd_data_reg;
    logic [INDEX_DEPTH-1:0] idx_valid_reg;
    logic                  wr_valid_reg;
    logic                  wr_valid_next;
    logic [7:0]            wr_hash;
    logic [IDX_AW-1:0]     wr_addr;
    logic                  wr2_valid_reg;
    logic [IDX_AW-1:0]     wr2_addr_reg;
    pixel_t                wr2_data_reg;
    logic [IDX_AW-1:0]     s1_addr;
    pixel_t                idx_val;

    // Decoder state.
    pixel_t      cur_pix_reg;
    logic [1:0]  pend_reg;
    logic [2:0]  need_reg;
    logic [23:0] gath_reg;
    logic [28:0] written_reg;
    logic [1:0]  pend_next;
    logic [2:0]  need_next;
    logic [23:0] gath_next;

    // Decode results.
    logic        dec_emit;
    logic [5:0]  dec_cnt;
    pixel_t      dec_pix;
    logic [7:0]  dg;
    logic        active;
    logic [28:0] remaining;
    logic [5:0]  dec_n;
    logic        dec_img_last;

    // Pixel emitter.
    logic        em_valid_reg;
    pixel_t      em_pix_reg;
    logic [5:0]  em_cnt_reg;
    logic        em_img_last_reg;
    logic        out_free;
    logic        em_push;
    logic        em_done;
    logic        em_free;

    // Output register.
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_last_reg;
    logic        m_user_reg;

    // Configuration register and read-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_count_reg <= PIX_COUNT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_PIXEL_COUNT) begin
            pix_count_reg <= pwdata[28:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PIXEL_COUNT) ? {3'b000, pix_count_reg} : 32'd0;

    // Input handshake: the byte stage takes a byte when it is empty or its current one leaves.
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            s1_first_reg <= s_accept;
        end
    end

    // Byte payload and the index value held while the byte waits for the emitter.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_byte_reg <= s_tdata;
            s1_last_reg <= s_tlast;
        end
        s1_held_reg <= idx_val;
    end

    // Index memory: one write port, one registered read port addressed by the incoming byte.
    assign wr_hash = pix_hash(cur_pix_reg);
    assign wr_addr = wr_hash[IDX_AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_valid_reg) begin
            idx_mem[wr_addr] <= cur_pix_reg;
        end
        if (s_accept) begin
            rd_data_reg <= idx_mem[s_tdata[IDX_AW-1:0]];
        end
    end

    // Valid bits and the copy of the last write, all dropped at the end of an image.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_valid_reg <= '0;
            wr_valid_reg  <= 1'b0;
            wr2_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= wr_valid_next;
            if (s1_fire && s1_last_reg) begin
                idx_valid_reg <= '0;
                wr2_valid_reg <= 1'b0;
            end else begin
                if (wr_valid_reg) begin
                    idx_valid_reg[wr_addr] <= 1'b1;
                end
                wr2_valid_reg <= wr_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr2_addr_reg <= wr_addr;
        wr2_data_reg <= cur_pix_reg;
    end

    // Lookup: in-flight writes newest first, then memory or reset value; held while waiting.
    assign s1_addr = s1_byte_reg[IDX_AW-1:0];

    always_comb begin
        priority if (!s1_first_reg) begin
            idx_val = s1_held_reg;
        end else if (wr_valid_reg && wr_addr == s1_addr) begin
            idx_val = cur_pix_reg;
        end else if (wr2_valid_reg && wr2_addr_reg == s1_addr) begin
            idx_val = wr2_data_reg;
        end else if (!idx_valid_reg[s1_addr]) begin
            idx_val = PIXEL_RESET;
        end else begin
            idx_val = rd_data_reg;
        end
    end

    // Chunk decode of the byte in the byte stage.
    always_comb begin
        dec_emit  = 1'b0;
        dec_cnt   = 6'd1;
        dec_pix   = cur_pix_reg;
        pend_next = pend_reg;
        need_next = need_reg;
        gath_next = gath_reg;
        dg        = {2'b00, gath_reg[5:0]} - 8'd32;
        if (pend_reg != OP_NONE) begin
            if (need_reg > 3'd1) begin
                // Payload byte of a chunk that is not complete yet.
                gath_next = {gath_reg[15:0], s1_byte_reg};
                need_next = need_reg - 3'd1;
            end else begin
                unique case (pend_reg)
                    OP_RGB: begin
                        dec_pix = '{r: gath_reg[15:8], g: gath_reg[7:0],
                                    b: s1_byte_reg, a: cur_pix_reg.a};
                    end
                    OP_RGBA: begin
                        dec_pix = '{r: gath_reg[23:16], g: gath_reg[15:8],
                                    b: gath_reg[7:0], a: s1_byte_reg};
                    end
                    default: begin
                        dec_pix.r = cur_pix_reg.r + dg - 8'd8 + {4'h0, s1_byte_reg[7:4]};
                        dec_pix.g = cur_pix_reg.g + dg;
                        dec_pix.b = cur_pix_reg.b + dg - 8'd8 + {4'h0, s1_byte_reg[3:0]};
                        dec_pix.a = cur_pix_reg.a;
                    end
                endcase
                pend_next = OP_NONE;
                need_next = 3'd0;
                gath_next = 24'd0;
                dec_emit  = 1'b1;
            end
        end else if (s1_byte_reg == TAG_RGB) begin
            pend_next = OP_RGB;
            need_next = NEED_RGB;
            gath_next = 24'd0;
        end else if (s1_byte_reg == TAG_RGBA) begin
            pend_next = OP_RGBA;
            need_next = NEED_RGBA;
            gath_next = 24'd0;
        end else begin
            unique case (s1_byte_reg[7:6])
                TAG2_INDEX: begin
                    dec_pix  = idx_val;
                    dec_emit = 1'b1;
                end
                TAG2_DIFF: begin
                    dec_pix.r = cur_pix_reg.r + {6'd0, s1_byte_reg[5:4]} - 8'd2;
                    dec_pix.g = cur_pix_reg.g + {6'd0, s1_byte_reg[3:2]} - 8'd2;
                    dec_pix.b = cur_pix_reg.b + {6'd0, s1_byte_reg[1:0]} - 8'd2;
                    dec_pix.a = cur_pix_reg.a;
                    dec_emit  = 1'b1;
                end
                TAG2_LUMA: begin
                    pend_next = OP_LUMA;
                    need_next = NEED_LUMA;
                    gath_next = {18'd0, s1_byte_reg[5:0]};
                end
                TAG2_RUN: begin
                    // Tags 0xFE and 0xFF are taken above, so the run length stays below 63.
                    dec_cnt  = s1_byte_reg[5:0] + 6'd1;
                    dec_emit = 1'b1;
                end
            endcase
        end
    end

    // Pixel count: cut a run to the pixels still missing and flag the final pixel.
    assign active    = written_reg < pix_count_reg;
    assign remaining = pix_count_reg - written_reg;

    always_comb begin
        if (!(active && dec_emit)) begin
            dec_n = 6'd0;
        end else if (remaining < {23'd0, dec_cnt}) begin
            dec_n = remaining[5:0];
        end else begin
            dec_n = dec_cnt;
        end
    end

    assign dec_img_last  = ({23'd0, dec_n} == remaining);
    assign s1_fire       = s1_valid_reg && (dec_n == 6'd0 || em_free);
    assign wr_valid_next = s1_fire && dec_n != 6'd0 && !s1_last_reg;

    // Decoder state update; the final byte of a stream returns everything to reset values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_pix_reg <= PIXEL_RESET;
            pend_reg    <= OP_NONE;
            need_reg    <= 3'd0;
            gath_reg    <= 24'd0;
            written_reg <= 29'd0;
        end else if (s1_fire) begin
            if (s1_last_reg) begin
                cur_pix_reg <= PIXEL_RESET;
                pend_reg    <= OP_NONE;
                need_reg    <= 3'd0;
                gath_reg    <= 24'd0;
                written_reg <= 29'd0;
            end else if (active) begin
                if (dec_emit) begin
                    cur_pix_reg <= dec_pix;
                end
                pend_reg    <= pend_next;
                need_reg    <= need_next;
                gath_reg    <= gath_next;
                written_reg <= written_reg + {23'd0, dec_n};
            end
        end
    end

    // Emitter: sends the pixels of one byte, one per cycle while the output register is free.
    assign out_free = !m_valid_reg || m_tready;
    assign em_push  = em_valid_reg && out_free;
    assign em_done  = em_push && em_cnt_reg == 6'd1;
    assign em_free  = !em_valid_reg || em_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_valid_reg <= 1'b0;
        end else if (s1_fire && dec_n != 6'd0) begin
            em_valid_reg <= 1'b1;
        end else if (em_done) begin
            em_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && dec_n != 6'd0) begin
            em_pix_reg      <= dec_pix;
            em_cnt_reg      <= dec_n;
            em_img_last_reg <= dec_img_last;
        end else if (em_push) begin
            em_cnt_reg <= em_cnt_reg - 6'd1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (em_push) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_push) begin
            m_data_reg <= {em_pix_reg.a, em_pix_reg.b, em_pix_reg.g, em_pix_reg.r};
            m_last_reg <= (em_cnt_reg == 6'd1);
            m_user_reg <= (em_cnt_reg == 6'd1) && em_img_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: sim/qoi_pixel_checker.sv
// Watches both streams and the configuration port. It decodes each accepted chunk byte
// on its own while the image still lacks pixels, and compares each pixel that leaves
// the decoder with the oldest pixel still owed.
module qoi_pixel_checker
    import qoi_dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    input  logic        m_tlast,
    input  logic        m_tuser,   // [0] image_last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          pixels_due,
    output int          mismatches
);

    localparam int         PALETTE_DEPTH    = 64;
    localparam logic [2:0] PIXEL_COUNT_ADDR = {REG_PIXEL_COUNT, 2'b00};

    // One pixel as it should appear on the result stream.
    typedef struct packed {
        pixel_t px;
        logic   run_last;
        logic   image_last;
    } owed_pixel_t;

    // Decoder state as this side sees it.
    pixel_t      palette [PALETTE_DEPTH];
    pixel_t      last_px;
    logic [1:0]  chunk_op;
    logic [2:0]  payload_left;
    logic [23:0] payload;
    logic [28:0] pixels_done;
    logic [28:0] image_size;
    owed_pixel_t owed_pixels [$];
    int          bad;

    // Palette slot of a color: (3r + 5g + 7b + 11a) mod 64.
    function automatic logic [5:0] color_slot(input pixel_t p);
        int sum;
        sum = 3 * p.r + 5 * p.g + 7 * p.b + 11 * p.a;
        return sum[5:0];
    endfunction

    // Everything except the pixel count goes back to its start value.
    task automatic restart_image();
        int i;
        for (i = 0; i < PALETTE_DEPTH; i++) begin
            palette[i] = PIXEL_RESET;
        end
        last_px      = PIXEL_RESET;
        chunk_op     = OP_NONE;
        payload_left = '0;
        payload      = '0;
        pixels_done  = '0;
    endtask

    // Queues copies of the current pixel, cut to what the image still lacks.
    task automatic emit_pixels(input int copies);
        int          room;
        int          n;
        int          k;
        owed_pixel_t e;
        palette[color_slot(last_px)] = last_px;
        room = (pixels_done < image_size) ? int'(image_size - pixels_done) : 0;
        n = (copies < room) ? copies : room;
        for (k = 0; k < n; k++) begin
            pixels_done  = pixels_done + 29'd1;
            e.px         = last_px;
            e.run_last   = (k == n - 1);
            e.image_last = (pixels_done >= image_size);
            owed_pixels.push_back(e);
        end
    endtask

    // Decodes one chunk byte into zero or more owed pixels.
    task automatic decode_chunk_byte(input logic [7:0] byt);
        pixel_t     nxt;
        logic [7:0] dg;
        nxt = last_px;
        if (chunk_op != OP_NONE) begin
            if (payload_left > 3'd1) begin
                payload      = {payload[15:0], byt};
                payload_left = payload_left - 3'd1;
            end else begin
                case (chunk_op)
                    OP_RGB: begin
                        nxt.r = payload[15:8];
                        nxt.g = payload[7:0];
                        nxt.b = byt;
                    end
                    OP_RGBA: begin
                        nxt.r = payload[23:16];
                        nxt.g = payload[15:8];
                        nxt.b = payload[7:0];
                        nxt.a = byt;
                    end
                    default: begin
                        // Luma: red and blue move with green plus their own nibble.
                        dg    = {2'b00, payload[5:0]} - 8'd32;
                        nxt.r = last_px.r + dg - 8'd8 + {4'b0000, byt[7:4]};
                        nxt.g = last_px.g + dg;
                        nxt.b = last_px.b + dg - 8'd8 + {4'b0000, byt[3:0]};
                    end
                endcase
                last_px      = nxt;
                chunk_op     = OP_NONE;
                payload_left = '0;
                payload      = '0;
                emit_pixels(1);
            end
        end else if (byt == TAG_RGB) begin
            chunk_op     = OP_RGB;
            payload_left = NEED_RGB;
            payload      = '0;
        end else if (byt == TAG_RGBA) begin
            chunk_op     = OP_RGBA;
            payload_left = NEED_RGBA;
            payload      = '0;
        end else begin
            case (byt[7:6])
                TAG2_INDEX: begin
                    last_px = palette[byt[5:0]];
                    emit_pixels(1);
                end
                TAG2_DIFF: begin
                    nxt.r   = last_px.r + {6'd0, byt[5:4]} - 8'd2;
                    nxt.g   = last_px.g + {6'd0, byt[3:2]} - 8'd2;
                    nxt.b   = last_px.b + {6'd0, byt[1:0]} - 8'd2;
                    last_px = nxt;
                    emit_pixels(1);
                end
                TAG2_LUMA: begin
                    chunk_op     = OP_LUMA;
                    payload_left = NEED_LUMA;
                    payload      = {18'd0, byt[5:0]};
                end
                default: begin
                    emit_pixels(int'(byt[5:0]) + 1);
                end
            endcase
        end
    endtask

    task automatic note_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
        bad++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // Inputs are predicted before outputs are compared; a pixel never leaves in
    // the cycle its byte is taken.
    always @(posedge aclk) begin : watch
        owed_pixel_t want;
        pixel_t      got;
        if (!aresetn) begin
            image_size = PIX_COUNT_RESET;
            restart_image();
            owed_pixels.delete();
            bad = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == PIXEL_COUNT_ADDR) begin
                image_size = pwdata[28:0];
            end
            if (s_tvalid && s_tready) begin
                if (pixels_done < image_size) begin
                    decode_chunk_byte(s_tdata);
                end
                if (s_tlast) begin
                    restart_image();
                end
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24]};
                if (owed_pixels.size() == 0) begin
                    bad++;
                    $display("%0t: pixel with none expected, expected nothing, got %08h",
                             $time, got);
                end else begin
                    want = owed_pixels.pop_front();
                    if (got.r !== want.px.r) note_mismatch("red", want.px.r, got.r);
                    if (got.g !== want.px.g) note_mismatch("green", want.px.g, got.g);
                    if (got.b !== want.px.b) note_mismatch("blue", want.px.b, got.b);
                    if (got.a !== want.px.a) note_mismatch("alpha", want.px.a, got.a);
                    if (m_tlast !== want.run_last) begin
                        note_mismatch("run_last", {7'd0, want.run_last}, {7'd0, m_tlast});
                    end
                    if (m_tuser !== want.image_last) begin
                        note_mismatch("image_last", {7'd0, want.image_last},
                                      {7'd0, m_tuser});
                    end
                end
            end
        end
        pixels_due <= owed_pixels.size();
        mismatches <= bad;
    end

endmodule

// File: sim/tb_qoi_image_decoder_core.sv
module tb_qoi_image_decoder_core;
    import qoi_dec_pkg::*;

    localparam logic [2:0] PIXEL_COUNT_ADDR = {REG_PIXEL_COUNT, 2'b00};
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    logic        m_tlast;
    logic        m_tuser;           // [0] image_last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int   pixels_due;
    int   mismatches;
    int   sent_items  = 0;
    int   quiet_cycles = 0;
    logic tx_burst    = 1'b0;
    logic [7:0] chunk_bytes [$];

    always #1 aclk = ~aclk;

    qoi_image_decoder_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    qoi_pixel_checker pixel_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pixels_due (pixels_due),
        .mismatches (mismatches)
    );

    // Offers one chunk byte after a random gap and waits until it is taken.
    task automatic send_chunk_byte(input logic [7:0] byt, input logic last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= byt;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_items++;
    endtask

    // Stops offering and waits until every owed pixel is out and the pipe is empty.
    task automatic finish_image();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pixels_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup cycle, then access cycle; the register takes the value when pready is high.
    task automatic write_pixel_count(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PIXEL_COUNT_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Appends one well-formed chunk with random content, or now and then a stray byte.
    task automatic add_random_chunk();
        int k;
        case ($urandom_range(0, 15))
            0, 1: begin
                chunk_bytes.push_back(TAG_RGB);
                for (k = 0; k < 3; k++) chunk_bytes.push_back(8'($urandom));
            end
            2, 3: begin
                chunk_bytes.push_back(TAG_RGBA);
                for (k = 0; k < 4; k++) chunk_bytes.push_back(8'($urandom));
            end
            4, 5, 6: chunk_bytes.push_back({TAG2_INDEX, 6'($urandom)});
            7, 8, 9: chunk_bytes.push_back({TAG2_DIFF, 6'($urandom)});
            10, 11: begin
                chunk_bytes.push_back({TAG2_LUMA, 6'($urandom)});
                chunk_bytes.push_back(8'($urandom));
            end
            12, 13, 14: chunk_bytes.push_back({TAG2_RUN, 6'($urandom_range(0, 61))});
            default: chunk_bytes.push_back(8'($urandom));
        endcase
    endtask

    // Ready side: random holds per item, bursts with no holds, and one long hold
    // that lets the decoder fill up and stall its input.
    initial begin : pixel_sink
        int   gap;
        int   taken;
        logic burst;
        taken = 0;
        burst = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (taken == HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (taken % 32 == 0) burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    // Ends the run when neither stream moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("qoi_image_decoder_core regression: fail");
            $finish;
        end
    end

    initial begin : stimulus
        logic [31:0] count;
        int          len;
        int          i;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pixel count still at its reset value: one pixel, then the image is complete
        // and the run byte is ignored.
        send_chunk_byte({TAG2_DIFF, 6'b010101}, 1'b0);
        send_chunk_byte({TAG2_RUN, 6'd3}, 1'b1);
        finish_image();

        // Zero pixel count: nothing comes out.
        write_pixel_count(32'd0);
        send_chunk_byte({TAG2_RUN, 6'd5}, 1'b0);
        send_chunk_byte({TAG2_DIFF, 6'b010101}, 1'b1);
        finish_image();

        // Every chunk kind at its extremes, then a stream that ends inside an RGB chunk.
        write_pixel_count(32'd400000000);
        send_chunk_byte(TAG_RGB, 1'b0);
        send_chunk_byte(8'h12, 1'b0);
        send_chunk_byte(8'h34, 1'b0);
        send_chunk_byte(8'h56, 1'b0);
        send_chunk_byte(TAG_RGBA, 1'b0);
        send_chunk_byte(8'h9A, 1'b0);
        send_chunk_byte(8'hBC, 1'b0);
        send_chunk_byte(8'hDE, 1'b0);
        send_chunk_byte(8'h80, 1'b0);
        send_chunk_byte({TAG2_DIFF, 6'b000000}, 1'b0);
        send_chunk_byte({TAG2_DIFF, 6'b111111}, 1'b0);
        send_chunk_byte({TAG2_LUMA, 6'd0}, 1'b0);
        send_chunk_byte(8'h00, 1'b0);
        send_chunk_byte({TAG2_LUMA, 6'd63}, 1'b0);
        send_chunk_byte(8'hFF, 1'b0);
        send_chunk_byte({TAG2_INDEX, 6'd0}, 1'b0);
        send_chunk_byte({TAG2_INDEX, 6'd63}, 1'b0);
        send_chunk_byte({TAG2_RUN, 6'd61}, 1'b0);
        send_chunk_byte(TAG_RGB, 1'b0);
        send_chunk_byte(8'h01, 1'b1);
        finish_image();

        // A run longer than the image is cut short.
        write_pixel_count(32'd5);
        send_chunk_byte({TAG2_RUN, 6'd61}, 1'b0);
        send_chunk_byte({TAG2_DIFF, 6'b000000}, 1'b1);
        finish_image();

        // Random images; each one is closed and fully drained before the next.
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0:       count = 32'd0;
                    1:       count = 32'd1;
                    2:       count = 32'h1FFF_FFFF;
                    3:       count = 32'd400000000;
                    default: count = $urandom_range(2, 300);
                endcase
                count[31:29] = 3'($urandom);
                write_pixel_count(count);
            end
            chunk_bytes.delete();
            len = $urandom_range(6, 40);
            while (chunk_bytes.size() < len) add_random_chunk();
            // Sometimes the last bytes are dropped, which can end the stream inside a chunk.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 2)) void'(chunk_bytes.pop_back());
            end
            tx_burst = ($urandom_range(0, 3) == 0);
            for (i = 0; i < chunk_bytes.size(); i++) begin
                send_chunk_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
            end
            finish_image();
        end

        if (mismatches == 0 && pixels_due == 0) begin
            $display("qoi_image_decoder_core regression: pass");
        end else begin
            $display("qoi_image_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
